### src/tdr_pkg.sv
package tdr_pkg;

    localparam int DEPTH_W = 24;
    localparam int CNT_W   = 17;
    localparam int ACC_W   = 64;
    localparam int DEN_W   = 35;
    localparam int QUO_W   = 24;
    localparam int COORD_W = 14;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 24'sh800000;
    localparam logic [CNT_W-1:0]          CNT_MAX   = 17'h1FFFF;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_BOX,
        ST_SETUP,
        ST_SIGN,
        ST_PIX,
        ST_DIV,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        DST_D,
        DST_NU,
        DST_NV,
        DST_DNR,
        DST_DNC,
        DST_N
    } t_dst;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

### src/tdr_if.sv
interface tdr_in_if import tdr_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic signed [15:0]         v0_x;
    logic signed [15:0]         v0_y;
    logic signed [DEPTH_W-1:0]  v0_z;
    logic signed [15:0]         v1_x;
    logic signed [15:0]         v1_y;
    logic signed [DEPTH_W-1:0]  v1_z;
    logic signed [15:0]         v2_x;
    logic signed [15:0]         v2_y;
    logic signed [DEPTH_W-1:0]  v2_z;
    logic [7:0]                 read_col;
    logic [7:0]                 read_row;

    modport source (output valid, kind, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, read_col, read_row, input ready);
    modport sink   (input valid, kind, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, read_col, read_row, output ready);
endinterface

interface tdr_out_if import tdr_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic signed [DEPTH_W-1:0]  depth_out;
    logic [CNT_W-1:0]           pixels_written;

    modport source (output valid, depth_out, pixels_written, input ready);
    modport sink   (input valid, depth_out, pixels_written, output ready);
endinterface

### src/tdr_div.sv
module tdr_div import tdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_dividend,
    input  logic [DEN_W-1:0]  i_divisor,
    output t_div_sts          o_sts,
    output logic [QUO_W-1:0]  o_quot
);

    localparam int SC_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [DEN_W-1:0] r_den;
    logic [SC_W-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W+1:0] trial;
    logic             ge;

    always_comb begin
        trial = {1'b0, r_rem, r_low[QUO_W-1]} - {2'b00, r_den};
        ge    = !trial[DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // quotient fits QUO_W bits, so the top part is already below the divisor
                r_rem  <= i_dividend[DEN_W+QUO_W-1:QUO_W];
                r_low  <= i_dividend[QUO_W-1:0];
                r_den  <= i_divisor;
                r_cnt  <= SC_W'(QUO_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= trial[DEN_W-1:0];
                end else begin
                    r_rem <= {r_rem[DEN_W-2:0], r_low[QUO_W-1]};
                end
                r_low <= {r_low[QUO_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_low;

endmodule

### src/triangle_depth_rasterizer.sv
// Triangle depth rasterizer over a WIDTH x HEIGHT depth store held in one
// synchronous RAM (one write and one registered read port).
// Requests arrive on i_in (valid/ready); each request gives exactly one result
// on o_out. kind clear fills the store with clear_depth, kind draw rasterises
// one triangle and reports the count of entries raised, kind read returns one
// entry (zero outside the store), the unused kind returns zeros at once.
// clear_depth is written over the APB port at byte address 0.
// A draw first builds its edge and depth equations on one shared 20x25
// multiplier, then steps over each pixel of the clamped bounding box; each
// covered pixel also takes the 24-step serial divider for z and the entry's
// read-modify-write.
// After reset the store is swept to the most negative depth, one entry a
// cycle over all WIDTH*HEIGHT entries, with i_in.ready low; APB writes are taken.
// Results go to an output register: a request is accepted while an earlier
// result still waits; when the receiver stalls, a finished result holds
// until that register frees.
module triangle_depth_rasterizer import tdr_pkg::*; #(
    parameter int WIDTH  = 256,
    parameter int HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdr_in_if.sink      i_in,
    tdr_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = WIDTH * HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int SETUP_STEPS = 26;
    localparam logic signed [17:0] XMAX = 18'((WIDTH - 1) * 16);
    localparam logic signed [17:0] YMAX = 18'((HEIGHT - 1) * 16);

    logic [DEPTH_W-1:0] mem [DEPTH];

    t_state r_state, n_state;

    logic signed [15:0]        r_vx0, r_vy0, r_vx1, r_vy1, r_vx2, r_vy2;
    logic signed [DEPTH_W-1:0] r_vz0, r_vz1, r_vz2;
    logic [7:0]                r_rcol, r_rrow;
    logic signed [DEPTH_W-1:0] r_clear;
    logic [DEPTH_W-1:0]        r_fill;
    logic                      r_boot;
    logic [AW-1:0]             r_sweep;

    t_coord                    r_x0, r_x1, r_y0, r_y1, r_col, r_row;
    logic                      r_empty;
    logic signed [16:0]        r_ex1, r_ex2, r_ey1, r_ey2;
    logic signed [18:0]        r_ex3, r_ey3;
    logic signed [24:0]        r_dz1, r_dz2;

    logic [4:0]                r_step;
    logic                      r_pv, r_psub, r_phi;
    t_dst                      r_pdst;
    logic signed [44:0]        r_prod;

    t_acc                      r_d, r_nu, r_nv, r_n, r_dnr, r_dnc;
    t_acc                      r_nu_c, r_nv_c, r_n_c;
    logic                      r_neg, r_zneg;
    logic [DEN_W-1:0]          r_den;
    logic [AW-1:0]             r_addr, r_addr_c;

    logic [CNT_W-1:0]          r_cnt;
    logic [DEPTH_W-1:0]        r_res_depth;
    logic [DEPTH_W-1:0]        r_rd_data;

    logic                      r_out_valid;
    logic [DEPTH_W-1:0]        r_out_depth;
    logic [CNT_W-1:0]          r_out_cnt;

    // clamped bounding box
    logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
    t_coord             bx0, bx1, by0, by1;

    always_comb begin
        lo_x = 18'(r_vx0);
        if (18'(r_vx1) < lo_x) lo_x = 18'(r_vx1);
        if (18'(r_vx2) < lo_x) lo_x = 18'(r_vx2);
        hi_x = 18'(r_vx0);
        if (18'(r_vx1) > hi_x) hi_x = 18'(r_vx1);
        if (18'(r_vx2) > hi_x) hi_x = 18'(r_vx2);
        lo_y = 18'(r_vy0);
        if (18'(r_vy1) < lo_y) lo_y = 18'(r_vy1);
        if (18'(r_vy2) < lo_y) lo_y = 18'(r_vy2);
        hi_y = 18'(r_vy0);
        if (18'(r_vy1) > hi_y) hi_y = 18'(r_vy1);
        if (18'(r_vy2) > hi_y) hi_y = 18'(r_vy2);
        if (lo_x < 0)    lo_x = '0;
        if (lo_y < 0)    lo_y = '0;
        if (hi_x > XMAX) hi_x = XMAX;
        if (hi_y > YMAX) hi_y = YMAX;
        bx0 = COORD_W'(lo_x >>> 4);
        by0 = COORD_W'(lo_y >>> 4);
        bx1 = COORD_W'((hi_x + 18'sd15) >>> 4);
        by1 = COORD_W'((hi_y + 18'sd15) >>> 4);
    end

    // setup multiplier: operand table, split into low and high halves
    logic signed [36:0] op_a;
    logic signed [24:0] op_b;
    t_dst               op_dst;
    logic               op_sub;
    logic signed [19:0] a_part;
    logic [3:0]         prod_idx;

    assign prod_idx = r_step[4:1];

    always_comb begin
        op_a   = 37'(r_ex1);
        op_b   = 25'(r_ey2);
        op_dst = DST_D;
        op_sub = 1'b0;
        case (prod_idx)
            4'd0:  begin op_a = 37'(r_ex1); op_b = 25'(r_ey2); op_dst = DST_D; end
            4'd1:  begin
                op_a = 37'(r_ex2); op_b = 25'(r_ey1); op_dst = DST_D; op_sub = 1'b1;
            end
            4'd2:  begin op_a = 37'(r_ex2); op_b = 25'(r_ey3); op_dst = DST_NU; end
            4'd3:  begin
                op_a = 37'(r_ex3); op_b = 25'(r_ey2); op_dst = DST_NU; op_sub = 1'b1;
            end
            4'd4:  begin op_a = 37'(r_ex1); op_b = 25'(r_ey3); op_dst = DST_NV; end
            4'd5:  begin
                op_a = 37'(r_ex3); op_b = 25'(r_ey1); op_dst = DST_NV; op_sub = 1'b1;
            end
            4'd6:  begin op_a = 37'(r_ex2); op_b = r_dz1; op_dst = DST_DNR; end
            4'd7:  begin
                op_a = 37'(r_ex1); op_b = r_dz2; op_dst = DST_DNR; op_sub = 1'b1;
            end
            4'd8:  begin op_a = 37'(r_ey2); op_b = r_dz1; op_dst = DST_DNC; end
            4'd9:  begin
                op_a = 37'(r_ey1); op_b = r_dz2; op_dst = DST_DNC; op_sub = 1'b1;
            end
            4'd10: begin op_a = $signed(r_d[36:0]);  op_b = 25'(r_vz0); op_dst = DST_N; end
            4'd11: begin op_a = $signed(r_nu[36:0]); op_b = r_dz1; op_dst = DST_N; end
            4'd12: begin
                op_a = $signed(r_nv[36:0]); op_b = r_dz2; op_dst = DST_N; op_sub = 1'b1;
            end
            default: begin op_a = '0; op_b = '0; end
        endcase
        if (r_step[0]) begin
            a_part = {op_a[36], op_a[36:18]};
        end else begin
            a_part = $signed({2'b00, op_a[17:0]});
        end
    end

    t_acc pp;
    always_comb begin
        pp = r_phi ? (t_acc'(r_prod) <<< 18) : t_acc'(r_prod);
        if (r_psub) pp = -pp;
    end

    // per-pixel coverage and stepping
    t_acc w0r;
    logic covered, at_row_end, at_box_end, in_range;
    always_comb begin
        w0r = r_d - r_nu + r_nv;
        if (r_neg) begin
            covered = (r_nu <= 0) && (r_nv >= 0) && (w0r <= 0);
        end else begin
            covered = (r_nu >= 0) && (r_nv <= 0) && (w0r >= 0);
        end
        at_row_end = (r_row == r_y1);
        at_box_end = at_row_end && (r_col == r_x1);
        in_range   = (32'(r_rcol) < WIDTH) && (32'(r_rrow) < HEIGHT);
    end

    // divider
    t_div_sts          div_sts;
    logic [QUO_W-1:0]  div_quot;
    logic              div_start;
    logic [ACC_W-1:0]  div_num;

    assign div_num = r_n < 0 ? ACC_W'(-r_n) : ACC_W'(r_n);

    tdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (r_den),
        .o_sts      (div_sts),
        .o_quot     (div_quot)
    );

    logic signed [DEPTH_W:0] z_new, z_old;
    logic                    z_wins;
    always_comb begin
        z_new  = r_zneg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        z_old  = (DEPTH_W+1)'($signed(r_rd_data));
        z_wins = z_old < z_new;
    end

    logic do_adv;
    assign do_adv = (r_state == ST_PIX && !covered) || (r_state == ST_DIV && div_sts.done);

    logic in_acc;
    assign in_acc = i_in.valid && i_in.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (r_sweep == AW'(DEPTH - 1)) n_state = r_boot ? ST_IDLE : ST_DONE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.kind)
                        KIND_CLEAR: n_state = ST_SWEEP;
                        KIND_DRAW:  n_state = ST_BOX;
                        KIND_READ:  n_state = ST_READ;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_BOX:   n_state = ST_SETUP;
            ST_SETUP: begin
                if (r_step == 5'(SETUP_STEPS)) n_state = ST_SIGN;
            end
            ST_SIGN:  n_state = (r_d == 0 || r_empty) ? ST_DONE : ST_PIX;
            ST_PIX: begin
                if (covered)         n_state = ST_DIV;
                else if (at_box_end) n_state = ST_DONE;
            end
            ST_DIV: begin
                if (div_sts.done) n_state = at_box_end ? ST_DONE : ST_PIX;
            end
            ST_READ:  n_state = in_range ? ST_RDATA : ST_DONE;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory and divider control
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [DEPTH_W-1:0] mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr;
        mem_raddr = r_addr;
        mem_wdata = z_new[DEPTH_W-1:0];
        div_start = 1'b0;
        case (r_state)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = r_fill;
            end
            ST_PIX: begin
                mem_re    = covered;
                div_start = covered;
            end
            ST_DIV:  mem_we = div_sts.done && z_wins;
            ST_READ: begin
                mem_re    = in_range;
                mem_raddr = AW'(32'(r_rrow) * WIDTH + 32'(r_rcol));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= mem[mem_raddr];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear <= DEPTH_MIN;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_clear <= pwdata[DEPTH_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (psel && !paddr[2]) ? {{(32-DEPTH_W){r_clear[DEPTH_W-1]}}, r_clear} : '0;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep     <= '0;
            r_fill      <= DEPTH_MIN;
            r_boot      <= 1'b1;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && o_out.ready && r_state != ST_DONE) r_out_valid <= 1'b0;

            case (r_state)
                ST_SWEEP: r_sweep <= r_sweep + 1'b1;
                ST_IDLE: begin
                    if (in_acc) begin
                        r_vx0 <= i_in.v0_x; r_vy0 <= i_in.v0_y; r_vz0 <= i_in.v0_z;
                        r_vx1 <= i_in.v1_x; r_vy1 <= i_in.v1_y; r_vz1 <= i_in.v1_z;
                        r_vx2 <= i_in.v2_x; r_vy2 <= i_in.v2_y; r_vz2 <= i_in.v2_z;
                        r_rcol      <= i_in.read_col;
                        r_rrow      <= i_in.read_row;
                        r_res_depth <= '0;
                        r_cnt       <= '0;
                        r_sweep     <= '0;
                        r_fill      <= r_clear;
                        r_boot      <= 1'b0;
                    end
                end
                ST_BOX: begin
                    r_x0    <= bx0;
                    r_x1    <= bx1;
                    r_y0    <= by0;
                    r_y1    <= by1;
                    r_empty <= (bx1 < bx0) || (by1 < by0);
                    r_ex1   <= 17'(r_vx1) - 17'(r_vx0);
                    r_ex2   <= 17'(r_vx2) - 17'(r_vx0);
                    r_ey1   <= 17'(r_vy1) - 17'(r_vy0);
                    r_ey2   <= 17'(r_vy2) - 17'(r_vy0);
                    r_ex3   <= 19'(r_vx0) - ((19'(bx0) <<< 4) + 19'sd8);
                    r_ey3   <= 19'(r_vy0) - ((19'(by0) <<< 4) + 19'sd8);
                    r_dz1   <= 25'(r_vz1) - 25'(r_vz0);
                    r_dz2   <= 25'(r_vz2) - 25'(r_vz0);
                    r_d     <= '0;
                    r_nu    <= '0;
                    r_nv    <= '0;
                    r_n     <= '0;
                    r_dnr   <= '0;
                    r_dnc   <= '0;
                    r_step  <= '0;
                    r_pv    <= 1'b0;
                end
                ST_SETUP: begin
                    if (r_step != 5'(SETUP_STEPS)) begin
                        r_step <= r_step + 1'b1;
                        r_pv   <= 1'b1;
                        r_prod <= a_part * op_b;
                        r_pdst <= op_dst;
                        r_psub <= op_sub;
                        r_phi  <= r_step[0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        case (r_pdst)
                            DST_D:   r_d   <= r_d + pp;
                            DST_NU:  r_nu  <= r_nu + pp;
                            DST_NV:  r_nv  <= r_nv + pp;
                            DST_DNR: r_dnr <= r_dnr + pp;
                            DST_DNC: r_dnc <= r_dnc + pp;
                            DST_N:   r_n   <= r_n + pp;
                            default: ;
                        endcase
                    end
                end
                ST_SIGN: begin
                    r_neg    <= r_d < 0;
                    r_den    <= DEN_W'(r_d < 0 ? -r_d : r_d);
                    // turn the raw products into per-row and per-column steps of z
                    r_dnr    <= -(r_dnr <<< 4);
                    r_dnc    <= r_dnc <<< 4;
                    r_nu_c   <= r_nu;
                    r_nv_c   <= r_nv;
                    r_n_c    <= r_n;
                    r_col    <= r_x0;
                    r_row    <= r_y0;
                    r_addr   <= AW'(32'(r_y0) * WIDTH + 32'(r_x0));
                    r_addr_c <= AW'(32'(r_y0) * WIDTH + 32'(r_x0));
                end
                ST_PIX: begin
                    if (covered) r_zneg <= (r_n < 0) ^ r_neg;
                end
                ST_DIV: begin
                    if (div_sts.done && z_wins && r_cnt != CNT_MAX) r_cnt <= r_cnt + 1'b1;
                end
                ST_RDATA: r_res_depth <= r_rd_data;
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_depth <= r_res_depth;
                        r_out_cnt   <= r_cnt;
                    end
                end
                default: ;
            endcase

            if (do_adv) begin
                if (at_row_end) begin
                    // next column, back to the top row of the box
                    r_col    <= r_col + 1'b1;
                    r_row    <= r_y0;
                    r_nu_c   <= r_nu_c + (t_acc'(r_ey2) <<< 4);
                    r_nv_c   <= r_nv_c + (t_acc'(r_ey1) <<< 4);
                    r_n_c    <= r_n_c + r_dnc;
                    r_nu     <= r_nu_c + (t_acc'(r_ey2) <<< 4);
                    r_nv     <= r_nv_c + (t_acc'(r_ey1) <<< 4);
                    r_n      <= r_n_c + r_dnc;
                    r_addr_c <= r_addr_c + 1'b1;
                    r_addr   <= r_addr_c + 1'b1;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_nu   <= r_nu - (t_acc'(r_ex2) <<< 4);
                    r_nv   <= r_nv - (t_acc'(r_ex1) <<< 4);
                    r_n    <= r_n + r_dnr;
                    r_addr <= r_addr + AW'(WIDTH);
                end
            end
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.depth_out      = r_out_depth;
    assign o_out.pixels_written = r_out_cnt;

endmodule

### src/tdr_checker.sv
module tdr_checker import tdr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DEPTH_W-1:0] i_out_depth,
    input logic [CNT_W-1:0]   i_out_cnt
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_depth)
            && $stable(i_out_cnt))
        else $error("stalled result changed or dropped");

    a_reset_out: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown straight after reset");

    a_reset_sweep: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_in_ready)
        else $error("request taken during the reset sweep");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_depth == '0 || i_out_cnt == '0))
        else $error("result carries both a depth and a count");

endmodule

bind triangle_depth_rasterizer tdr_checker u_tdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_depth (o_out.depth_out),
    .i_out_cnt   (o_out.pixels_written)
);

### tb/tdr_tb_if.sv
`timescale 1ns / 100ps

// APB-style register port as the testbench drives it
interface tdr_apb_if;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modport source (output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
    modport sink   (input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

### tb/triangle_depth_rasterizer_tb.sv
`timescale 1ns / 100ps

module triangle_depth_rasterizer_tb import tdr_pkg::*; ;

    localparam int GRID_W       = 256;
    localparam int GRID_H       = 256;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int ITEMS_PHASE  = 240;
    localparam int N_DIRECTED   = 22;
    localparam logic [2:0] REG_CLEAR_DEPTH = 3'd0;
    localparam logic [1:0] KIND_SPARE      = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x0, y0;
        logic signed [23:0] z0;
        logic signed [15:0] x1, y1;
        logic signed [23:0] z1;
        logic signed [15:0] x2, y2;
        logic signed [23:0] z2;
        logic [7:0]         col, row;
    } t_req;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [CNT_W-1:0]          count;
    } t_res;

    typedef struct packed {
        t_req rq;
        bit   typed;
        t_res res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    tdr_in_if  in_ch ();
    tdr_out_if out_ch ();
    tdr_apb_if apb ();

    triangle_depth_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (apb.psel),
        .penable (apb.penable),
        .pwrite  (apb.pwrite),
        .paddr   (apb.paddr),
        .pwdata  (apb.pwdata),
        .prdata  (apb.prdata),
        .pready  (apb.pready)
    );

    // predicted contents of the depth store and its clear value
    logic signed [DEPTH_W-1:0] depth_img [0:GRID_W*GRID_H-1];
    logic signed [DEPTH_W-1:0] clear_val;

    t_res     pending_res [$];
    t_dir_row dir_tab [N_DIRECTED];
    int       errors;
    int       checked;
    int       sent;
    int       draws_hit;
    int       cycles;
    int       tx_idle_pct;
    int       rx_idle_pct;
    bit       hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_res.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint floor16(longint a);
        return (a >= 0) ? a / 16 : -((-a + 15) / 16);
    endfunction

    function automatic longint ceil16(longint a);
        return (a >= 0) ? (a + 15) / 16 : -((-a) / 16);
    endfunction

    function automatic logic [CNT_W-1:0] raster_triangle(t_req r);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint lox, hix, loy, hiy, ex1, ex2, ey1, ey2, d;
        longint ex3, ey3, nu, nv, w0, w1, w2, den, z;
        int     cnt;
        ax = r.x0; ay = r.y0; az = r.z0;
        bx = r.x1; by = r.y1; bz = r.z1;
        cx = r.x2; cy = r.y2; cz = r.z2;
        cnt = 0;
        ex1 = bx - ax; ex2 = cx - ax;
        ey1 = by - ay; ey2 = cy - ay;
        d = ex1 * ey2 - ex2 * ey1;
        if (d == 0)
            return '0;
        lox = ax; if (bx < lox) lox = bx; if (cx < lox) lox = cx;
        hix = ax; if (bx > hix) hix = bx; if (cx > hix) hix = cx;
        loy = ay; if (by < loy) loy = by; if (cy < loy) loy = cy;
        hiy = ay; if (by > hiy) hiy = by; if (cy > hiy) hiy = cy;
        if (lox < 0) lox = 0;
        if (loy < 0) loy = 0;
        if (hix > (GRID_W - 1) * 16) hix = (GRID_W - 1) * 16;
        if (hiy > (GRID_H - 1) * 16) hiy = (GRID_H - 1) * 16;
        for (longint c = floor16(lox); c <= ceil16(hix); c++) begin
            for (longint rw = floor16(loy); rw <= ceil16(hiy); rw++) begin
                ex3 = ax - (16 * c + 8);
                ey3 = ay - (16 * rw + 8);
                nu = ex2 * ey3 - ex3 * ey2;
                nv = ex1 * ey3 - ex3 * ey1;
                w1 = nu; w2 = -nv; w0 = d - nu + nv; den = d;
                if (den < 0) begin
                    den = -den; w0 = -w0; w1 = -w1; w2 = -w2;
                end
                if (w0 >= 0 && w1 >= 0 && w2 >= 0) begin
                    z = (w0 * az + w1 * bz + w2 * cz) / den;
                    if (longint'(depth_img[rw * GRID_W + c]) < z) begin
                        depth_img[rw * GRID_W + c] = z[DEPTH_W-1:0];
                        if (cnt < int'(CNT_MAX)) cnt++;
                    end
                end
            end
        end
        return cnt[CNT_W-1:0];
    endfunction

    // advance the predicted store by one request and give its result
    function automatic t_res apply_request(t_req r);
        t_res o;
        o = '0;
        case (r.kind)
            KIND_CLEAR: for (int i = 0; i < GRID_W * GRID_H; i++) depth_img[i] = clear_val;
            KIND_DRAW:  o.count = raster_triangle(r);
            KIND_READ:  o.depth = depth_img[int'(r.row) * GRID_W + int'(r.col)];
            default:    ;
        endcase
        return o;
    endfunction

    function automatic t_req mk_req(logic [1:0] k, int ax, int ay, int az, int bx, int by,
                                    int bz, int cx, int cy, int cz, int c, int rw);
        t_req r;
        r.kind = k;
        r.x0 = ax[15:0]; r.y0 = ay[15:0]; r.z0 = az[23:0];
        r.x1 = bx[15:0]; r.y1 = by[15:0]; r.z1 = bz[23:0];
        r.x2 = cx[15:0]; r.y2 = cy[15:0]; r.z2 = cz[23:0];
        r.col = c[7:0]; r.row = rw[7:0];
        return r;
    endfunction

    function automatic int rand_z();
        return int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick, bx0, by0, span, sel;
        pick = $urandom_range(0, 99);
        r = mk_req(KIND_DRAW, 0, 0, rand_z(), 0, 0, rand_z(), 0, 0, rand_z(),
                   $urandom_range(0, 255), $urandom_range(0, 255));
        if (pick < 38) begin
            r.kind = KIND_READ;
            if ($urandom_range(0, 1) != 0) begin
                r.col = 8'($urandom_range(0, 50));
                r.row = 8'($urandom_range(0, 50));
            end
        end else if (pick < 41) begin
            r.kind = KIND_SPARE;
            r.x0 = 16'($urandom); r.y0 = 16'($urandom); r.x1 = 16'($urandom);
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                // off-store noise: every vertex beyond one side of the store
                r.x0 = 16'($urandom); r.x1 = 16'($urandom); r.x2 = 16'($urandom);
                if ($urandom_range(0, 1) != 0) begin
                    r.y0 = 16'(-1 - int'($urandom_range(0, 32767)));
                    r.y1 = 16'(-1 - int'($urandom_range(0, 32767)));
                    r.y2 = 16'(-1 - int'($urandom_range(0, 32767)));
                end else begin
                    r.y0 = 16'($urandom_range(4096, 32767));
                    r.y1 = 16'($urandom_range(4096, 32767));
                    r.y2 = 16'($urandom_range(4096, 32767));
                end
            end else begin
                span = (sel < 20) ? 512 : 96;
                if ($urandom_range(0, 2) != 0) begin
                    bx0 = int'($urandom_range(0, 750)) - 48;
                    by0 = int'($urandom_range(0, 750)) - 48;
                end else begin
                    bx0 = int'($urandom_range(0, 4150)) - 48;
                    by0 = int'($urandom_range(0, 4150)) - 48;
                end
                r.x0 = 16'(bx0 + int'($urandom_range(0, span)));
                r.y0 = 16'(by0 + int'($urandom_range(0, span)));
                r.x1 = 16'(bx0 + int'($urandom_range(0, span)));
                r.y1 = 16'(by0 + int'($urandom_range(0, span)));
                r.x2 = 16'(bx0 + int'($urandom_range(0, span)));
                r.y2 = 16'(by0 + int'($urandom_range(0, span)));
                if (sel >= 90) begin
                    // collinear: third vertex on the line through the first two
                    r.x2 = 16'(int'(r.x0) + 2 * (int'(r.x1) - int'(r.x0)));
                    r.y2 = 16'(int'(r.y0) + 2 * (int'(r.y1) - int'(r.y0)));
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("[%0d] %s mismatch: got %0d, expected %0d", cycles, field, got, want);
        errors++;
    endtask

    task automatic send_request(t_req r, bit typed, t_res want);
        t_res p;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= r.kind;
        in_ch.v0_x     <= r.x0; in_ch.v0_y <= r.y0; in_ch.v0_z <= r.z0;
        in_ch.v1_x     <= r.x1; in_ch.v1_y <= r.y1; in_ch.v1_z <= r.z1;
        in_ch.v2_x     <= r.x2; in_ch.v2_y <= r.y2; in_ch.v2_z <= r.z2;
        in_ch.read_col <= r.col;
        in_ch.read_row <= r.row;
        do @(posedge i_clk); while (!in_ch.ready);
        p = apply_request(r);
        if (r.kind == KIND_DRAW && p.count != 0) draws_hit++;
        pending_res.push_back(typed ? want : p);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_clear_depth(logic signed [DEPTH_W-1:0] v);
        apb.psel    <= 1'b1;
        apb.penable <= 1'b0;
        apb.pwrite  <= 1'b1;
        apb.paddr   <= REG_CLEAR_DEPTH;
        apb.pwdata  <= 32'(v);
        @(posedge i_clk);
        apb.penable <= 1'b1;
        @(posedge i_clk);
        apb.psel    <= 1'b0;
        apb.penable <= 1'b0;
        apb.pwrite  <= 1'b0;
        clear_val = v;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_res.size() == 0) begin
                $display("[%0d] result with nothing expected", cycles);
                errors++;
            end else begin
                want = pending_res.pop_front();
                checked++;
                if (out_ch.depth_out !== want.depth)
                    report_mismatch("depth_out", out_ch.depth_out, want.depth);
                if (out_ch.pixels_written !== want.count)
                    report_mismatch("pixels_written", out_ch.pixels_written, want.count);
            end
        end
    end

    // receiver: random back-pressure, or a long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        t_res nil;
        nil = '0;
        errors = 0; checked = 0; sent = 0; draws_hit = 0; cycles = 0;
        tx_idle_pct = 0; rx_idle_pct = 0; hold_req = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_CLEAR;
        in_ch.v0_x = '0; in_ch.v0_y = '0; in_ch.v0_z = '0;
        in_ch.v1_x = '0; in_ch.v1_y = '0; in_ch.v1_z = '0;
        in_ch.v2_x = '0; in_ch.v2_y = '0; in_ch.v2_z = '0;
        in_ch.read_col = '0; in_ch.read_row = '0;
        apb.psel = 1'b0; apb.penable = 1'b0; apb.pwrite = 1'b0;
        apb.paddr = '0; apb.pwdata = '0;
        clear_val = DEPTH_MIN;
        for (int i = 0; i < GRID_W * GRID_H; i++) depth_img[i] = DEPTH_MIN;

        dir_tab[0]  = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 0,0), 1'b1,
                        '{DEPTH_MIN, 17'd0}};
        dir_tab[1]  = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 255,255), 1'b1,
                        '{DEPTH_MIN, 17'd0}};
        dir_tab[2]  = '{mk_req(KIND_SPARE, -1,-1,-1, -1,-1,-1, -1,-1,-1, 255,255), 1'b1,
                        '{24'sd0, 17'd0}};
        dir_tab[3]  = '{mk_req(KIND_DRAW, 0,0,5, 160,160,5, 320,320,5, 0,0), 1'b1,
                        '{24'sd0, 17'd0}};
        dir_tab[4]  = '{mk_req(KIND_DRAW, 40,40,9, 40,40,9, 40,40,9, 0,0), 1'b1,
                        '{24'sd0, 17'd0}};
        dir_tab[5]  = '{mk_req(KIND_DRAW, -32768,-32768,-8388608, 32767,-32768,8388607,
                        -32768,-32700,0, 0,0), 1'b1, '{24'sd0, 17'd0}};
        dir_tab[6]  = '{mk_req(KIND_DRAW, 32767,32767,8388607, 4096,32767,-8388608,
                        32767,4096,1, 0,0), 1'b1, '{24'sd0, 17'd0}};
        // edges pass exactly through pixel centres
        dir_tab[7]  = '{mk_req(KIND_DRAW, 8,8,100, 88,8,100, 8,88,100, 0,0), 1'b0, nil};
        dir_tab[8]  = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 0,0), 1'b0, nil};
        dir_tab[9]  = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 5,0), 1'b0, nil};
        dir_tab[10] = '{mk_req(KIND_DRAW, 8,8,100, 88,8,100, 8,88,100, 0,0), 1'b0, nil};
        dir_tab[11] = '{mk_req(KIND_DRAW, 8,8,200, 8,88,300, 88,8,-50, 0,0), 1'b0, nil};
        dir_tab[12] = '{mk_req(KIND_DRAW, 0,0,8388607, 1024,0,-8388608, 0,1024,0, 0,0),
                        1'b0, nil};
        dir_tab[13] = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 10,10), 1'b0, nil};
        dir_tab[14] = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 63,0), 1'b0, nil};
        dir_tab[15] = '{mk_req(KIND_DRAW, 300,300,8388607, 360,310,8388607,
                        320,380,8388607, 0,0), 1'b0, nil};
        dir_tab[16] = '{mk_req(KIND_DRAW, -100,-100,7, 200,-50,-7000, 50,300,70000, 0,0),
                        1'b0, nil};
        dir_tab[17] = '{mk_req(KIND_DRAW, 4000,4000,1, 4200,4050,2, 4050,4300,3, 0,0),
                        1'b0, nil};
        dir_tab[18] = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 255,255), 1'b0, nil};
        dir_tab[19] = '{mk_req(KIND_CLEAR, 0,0,0, 0,0,0, 0,0,0, 0,0), 1'b1,
                        '{24'sd0, 17'd0}};
        dir_tab[20] = '{mk_req(KIND_READ, 0,0,0, 0,0,0, 0,0,0, 3,3), 1'b1,
                        '{24'sh123456, 17'd0}};
        dir_tab[21] = '{mk_req(KIND_DRAW, 20,30,1193047, 70,40,1193047, 40,90,1193047, 0,0),
                        1'b0, nil};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_clear_depth(24'sh123456);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);

        for (int ph = 0; ph < 3; ph++) begin
            drain();
            tx_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 48 : 0;
            rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 35 : 0;
            write_clear_depth((ph == 0) ? 24'(rand_z()) : (ph == 1) ? 24'sh7FFFFF : DEPTH_MIN);
            send_request(mk_req(KIND_CLEAR, 0,0,0, 0,0,0, 0,0,0, 0,0), 1'b0, nil);
            for (int k = 0; k < ITEMS_PHASE; k++) begin
                // stall the output long enough for the input to back up
                if (k == 100) hold_req = 1'b1;
                send_request(random_request(), 1'b0, nil);
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("sent %0d requests, %0d results checked, %0d draws raised the store",
                 sent, checked, draws_hit);
        $display("covered clear values at both extremes, off-store, degenerate and edge cases");
        if (errors == 0 && pending_res.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### sim.f
src/tdr_pkg.sv
src/tdr_if.sv
src/tdr_div.sv
src/triangle_depth_rasterizer.sv
src/tdr_checker.sv
tb/tdr_tb_if.sv
tb/triangle_depth_rasterizer_tb.sv
